// File: rtl/plmi_pkg.sv
`default_nettype none
package plmi_pkg;

  localparam int MAP_DEPTH = 256;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int CNT_W     = ADDR_W + 1;

  localparam int POS_W     = 32;
  localparam int KIDX_W    = 8;
  localparam int KCNT_W    = 9;
  localparam int REGION_W  = 2;

  localparam logic [KCNT_W-1:0] KCNT_RESET = KCNT_W'(2);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [REGION_W-1:0] REGION_LEFT   = 2'd0;
  localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd1;
  localparam logic [REGION_W-1:0] REGION_RIGHT  = 2'd2;

  // |a*b/c| is clipped to 2^TERM_EXP before the final add
  localparam int PROD_W   = 2 * POS_W;
  localparam int TERM_EXP = 34;
  localparam int QUOT_W   = TERM_EXP + 1;
  localparam int HI_W     = PROD_W - QUOT_W;
  localparam int QCNT_W   = $clog2(QUOT_W);
  localparam int TOT_W    = QUOT_W + 2;

  localparam logic [QUOT_W-1:0] TERM_LIMIT = QUOT_W'(1) << TERM_EXP;

endpackage
`default_nettype wire

// File: rtl/plmi_if.sv
`default_nettype none
interface plmi_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic        [plmi_pkg::KIDX_W-1:0] knot_index;
  logic signed [plmi_pkg::POS_W-1:0]  old_knot;
  logic signed [plmi_pkg::POS_W-1:0]  new_knot;
  logic signed [plmi_pkg::POS_W-1:0]  query_position;

  modport source (output valid, kind, knot_index, old_knot, new_knot, query_position,
                  input ready);
  modport sink   (input valid, kind, knot_index, old_knot, new_knot, query_position,
                  output ready);
endinterface

interface plmi_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [plmi_pkg::POS_W-1:0]    mapped_position;
  logic        [plmi_pkg::REGION_W-1:0] region;
  logic                                 error;
  logic                                 saturated;

  modport source (output valid, mapped_position, region, error, saturated, input ready);
  modport sink   (input valid, mapped_position, region, error, saturated, output ready);
endinterface

interface plmi_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [plmi_pkg::KCNT_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: rtl/plmi_knot_mem.sv
`default_nettype none
module plmi_knot_mem (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [plmi_pkg::ADDR_W-1:0]   wr_addr,
  input  wire logic [plmi_pkg::POS_W-1:0]    wr_old,
  input  wire logic [plmi_pkg::POS_W-1:0]    wr_new,
  input  wire logic [plmi_pkg::ADDR_W-1:0]   rd_addr,
  output      logic [plmi_pkg::POS_W-1:0]    rd_old,
  output      logic [plmi_pkg::POS_W-1:0]    rd_new
);

  logic [plmi_pkg::POS_W-1:0] old_mem [plmi_pkg::MAP_DEPTH];
  logic [plmi_pkg::POS_W-1:0] new_mem [plmi_pkg::MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      old_mem[wr_addr] <= wr_old;
      new_mem[wr_addr] <= wr_new;
    end
    rd_old <= old_mem[rd_addr];
    rd_new <= new_mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: rtl/plmi_div.sv
`default_nettype none
module plmi_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [plmi_pkg::PROD_W-1:0]   dividend,
  input  wire logic [plmi_pkg::POS_W-1:0]    divisor,
  output      logic                          done,
  output      logic [plmi_pkg::QUOT_W-1:0]   quot
);

  logic                          busy_r;
  logic                          done_r;
  logic [plmi_pkg::QCNT_W-1:0]   cnt_r;
  logic [plmi_pkg::POS_W-1:0]    rem_r;
  logic [plmi_pkg::POS_W-1:0]    rem_nxt;
  logic [plmi_pkg::QUOT_W-1:0]   rq_r;
  logic [plmi_pkg::QUOT_W-1:0]   rq_nxt;
  logic [plmi_pkg::POS_W-1:0]    dvs_r;
  logic [plmi_pkg::QUOT_W-1:0]   quot_r;
  logic [plmi_pkg::POS_W:0]      trial;
  logic [plmi_pkg::POS_W:0]      diff;
  logic                          ge;
  logic                          ovf;
  logic                          last_step;

  // quotient needs more than QUOT_W bits when the top dividend bits reach the divisor
  assign ovf       = plmi_pkg::POS_W'(dividend[plmi_pkg::PROD_W-1 -: plmi_pkg::HI_W]) >= divisor;
  assign trial     = {rem_r, rq_r[plmi_pkg::QUOT_W-1]};
  assign diff      = trial - {1'b0, dvs_r};
  assign ge        = trial >= {1'b0, dvs_r};
  assign rem_nxt   = ge ? diff[plmi_pkg::POS_W-1:0] : trial[plmi_pkg::POS_W-1:0];
  assign rq_nxt    = {rq_r[plmi_pkg::QUOT_W-2:0], ge};
  assign last_step = cnt_r == plmi_pkg::QCNT_W'(plmi_pkg::QUOT_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= !ovf;
        done_r <= ovf;
      end else if (busy_r && last_step) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= '0;
      dvs_r  <= divisor;
      rem_r  <= plmi_pkg::POS_W'(dividend[plmi_pkg::PROD_W-1 -: plmi_pkg::HI_W]);
      rq_r   <= dividend[plmi_pkg::QUOT_W-1:0];
      quot_r <= plmi_pkg::TERM_LIMIT;
    end else if (busy_r) begin
      cnt_r <= cnt_r + plmi_pkg::QCNT_W'(1);
      rem_r <= rem_nxt;
      rq_r  <= rq_nxt;
      if (last_step) begin
        quot_r <= (rq_nxt > plmi_pkg::TERM_LIMIT) ? plmi_pkg::TERM_LIMIT : rq_nxt;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

// File: rtl/piecewise_linear_map_interpolator.sv
// Load item: written to the knot memories at the transfer.
// Query item: a linear scan reads one knot per cycle until a knot lies above the query
// or the last active knot is reached, then the bounding knots are fetched and a 35-step
// divider runs, skipped for a zero divisor, ended at once when the quotient overflows.
// One item at a time, taken only while idle; a waiting result holds no loads back.
// Reset clears control and sets knot_count to 2; knot memories are not cleared.
`default_nettype none
module piecewise_linear_map_interpolator (
  input  wire logic   clk,
  input  wire logic   rst_n,
  plmi_in_if.sink     in_ch,
  plmi_out_if.source  out_ch,
  plmi_cfg_if.sink    cfg_ch
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_FETCH_A = 4'd2;
  localparam logic [3:0] S_FETCH_B = 4'd3;
  localparam logic [3:0] S_FETCH_W = 4'd4;
  localparam logic [3:0] S_OPS     = 4'd5;
  localparam logic [3:0] S_MUL     = 4'd6;
  localparam logic [3:0] S_DIVS    = 4'd7;
  localparam logic [3:0] S_DIV     = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  localparam int PW = plmi_pkg::POS_W;
  localparam int AW = plmi_pkg::ADDR_W;
  localparam int CW = plmi_pkg::CNT_W;

  function automatic logic signed [PW:0] sub_ext(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b);
    sub_ext = {a[PW-1], a} - {b[PW-1], b};
  endfunction

  function automatic logic [PW-1:0] mag(input logic signed [PW:0] v);
    logic [PW:0] n;
    n   = v[PW] ? -v : v;
    mag = n[PW-1:0];
  endfunction

  logic [3:0]                        state_r;
  logic [3:0]                        state_nxt;
  logic [plmi_pkg::KCNT_W-1:0]       knot_count_r;
  logic [CW-1:0]                     n_act;
  logic [CW-1:0]                     last_n;

  logic                              in_fire;
  logic                              wr_en;
  logic [AW-1:0]                     rd_addr;
  logic [PW-1:0]                     rd_old;
  logic [PW-1:0]                     rd_new;

  logic signed [PW-1:0]              pos_r;
  logic [CW-1:0]                     iss_r;
  logic [CW-1:0]                     chk_r;
  logic                              pend_r;
  logic                              brk;
  logic [AW-1:0]                     addr_a_r;
  logic [AW-1:0]                     addr_b_r;
  logic [plmi_pkg::REGION_W-1:0]     region_r;

  logic signed [PW-1:0]              oa_r;
  logic signed [PW-1:0]              na_r;
  logic signed [PW-1:0]              ob_r;
  logic signed [PW-1:0]              nb_r;
  logic signed [PW:0]                op_a;
  logic signed [PW:0]                op_b;
  logic signed [PW:0]                op_c;
  logic [PW-1:0]                     mag_a_r;
  logic [PW-1:0]                     mag_b_r;
  logic [PW-1:0]                     mag_c_r;
  logic                              neg_r;
  logic                              czero_r;
  logic                              err_r;
  logic signed [PW-1:0]              base_r;
  logic [plmi_pkg::PROD_W-1:0]       prod_r;
  logic [plmi_pkg::QUOT_W-1:0]       q_r;

  logic                              div_done;
  logic [plmi_pkg::QUOT_W-1:0]       div_quot;

  logic signed [plmi_pkg::TOT_W-1:0] term;
  logic signed [plmi_pkg::TOT_W-1:0] total;
  logic                              ovr;
  logic signed [PW-1:0]              res_pos;
  logic                              out_free;
  logic                              fin_load;

  logic                              out_valid_r;
  logic signed [PW-1:0]              out_pos_r;
  logic [plmi_pkg::REGION_W-1:0]     out_region_r;
  logic                              out_error_r;
  logic                              out_sat_r;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= plmi_pkg::KCNT_RESET;
    end else if (cfg_ch.valid) begin
      knot_count_r <= cfg_ch.data;
    end
  end

  always_comb begin
    priority if (knot_count_r == '0) begin
      n_act = CW'(1);
    end else if (32'(knot_count_r) > 32'(plmi_pkg::MAP_DEPTH)) begin
      n_act = CW'(plmi_pkg::MAP_DEPTH);
    end else begin
      n_act = CW'(knot_count_r);
    end
  end

  assign last_n = n_act - CW'(1);

  // knot store
  assign in_ch.ready = state_r == S_IDLE;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign wr_en       = in_fire && (in_ch.kind == plmi_pkg::KIND_LOAD)
                       && (32'(in_ch.knot_index) < 32'(plmi_pkg::MAP_DEPTH));

  always_comb begin
    unique case (state_r)
      S_SCAN:    rd_addr = iss_r[AW-1:0];
      S_FETCH_A: rd_addr = addr_a_r;
      default:   rd_addr = addr_b_r;
    endcase
  end

  plmi_knot_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_ch.knot_index)),
    .wr_old  (in_ch.old_knot),
    .wr_new  (in_ch.new_knot),
    .rd_addr (rd_addr),
    .rd_old  (rd_old),
    .rd_new  (rd_new)
  );

  assign brk = $signed(rd_old) > pos_r;

  // operands of base +/- a*b/c
  assign op_b = sub_ext(nb_r, na_r);
  assign op_c = sub_ext(ob_r, oa_r);

  always_comb begin
    unique case (region_r)
      plmi_pkg::REGION_LEFT:   op_a = sub_ext(oa_r, pos_r);
      plmi_pkg::REGION_INSIDE: op_a = sub_ext(pos_r, oa_r);
      default:                 op_a = sub_ext(pos_r, ob_r);
    endcase
  end

  plmi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DIVS),
    .dividend (prod_r),
    .divisor  (mag_c_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  // result assembly and saturation
  assign term    = neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
  assign total   = plmi_pkg::TOT_W'(base_r) + term;
  assign ovr     = !((&total[plmi_pkg::TOT_W-1:PW-1]) || !(|total[plmi_pkg::TOT_W-1:PW-1]));
  assign res_pos = ovr ? (total[plmi_pkg::TOT_W-1] ? {1'b1, {(PW-1){1'b0}}}
                                                    : {1'b0, {(PW-1){1'b1}}})
                       : total[PW-1:0];

  assign out_free = !out_valid_r || out_ch.ready;
  assign fin_load = (state_r == S_FIN) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.kind == plmi_pkg::KIND_QUERY) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (pend_r && (brk || chk_r == last_n)) state_nxt = S_FETCH_A;
      end
      S_FETCH_A: state_nxt = S_FETCH_B;
      S_FETCH_B: state_nxt = S_FETCH_W;
      S_FETCH_W: state_nxt = S_OPS;
      S_OPS:     state_nxt = S_MUL;
      S_MUL:     state_nxt = czero_r ? S_FIN : S_DIVS;
      S_DIVS:    state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= state_r == S_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pos_r <= in_ch.query_position;
      iss_r <= '0;
    end
    if (state_r == S_SCAN) begin
      iss_r <= iss_r + CW'(1);
      chk_r <= iss_r;
      if (pend_r) begin
        priority if (brk && chk_r == '0) begin
          region_r <= plmi_pkg::REGION_LEFT;
          addr_a_r <= '0;
          addr_b_r <= last_n[AW-1:0];
        end else if (brk) begin
          region_r <= plmi_pkg::REGION_INSIDE;
          addr_a_r <= AW'(chk_r - CW'(1));
          addr_b_r <= chk_r[AW-1:0];
        end else begin
          region_r <= plmi_pkg::REGION_RIGHT;
          addr_a_r <= '0;
          addr_b_r <= last_n[AW-1:0];
        end
      end
    end
    if (state_r == S_FETCH_B) begin
      oa_r <= rd_old;
      na_r <= rd_new;
    end
    if (state_r == S_FETCH_W) begin
      ob_r <= rd_old;
      nb_r <= rd_new;
    end
    if (state_r == S_OPS) begin
      mag_a_r <= mag(op_a);
      mag_b_r <= mag(op_b);
      mag_c_r <= mag(op_c);
      neg_r   <= op_a[PW] ^ op_b[PW] ^ op_c[PW] ^ (region_r == plmi_pkg::REGION_LEFT);
      czero_r <= op_c == '0;
      err_r   <= (op_c == '0) && (region_r != plmi_pkg::REGION_INSIDE);
      base_r  <= (region_r == plmi_pkg::REGION_RIGHT) ? nb_r : na_r;
    end
    if (state_r == S_MUL) begin
      prod_r <= mag_a_r * mag_b_r;
      q_r    <= '0;
    end
    if (state_r == S_DIV && div_done) begin
      q_r <= div_quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_region_r <= region_r;
      out_error_r  <= err_r;
      out_pos_r    <= err_r ? '0 : res_pos;
      out_sat_r    <= !err_r && ovr;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.mapped_position = out_pos_r;
  assign out_ch.region          = out_region_r;
  assign out_ch.error           = out_error_r;
  assign out_ch.saturated       = out_sat_r;

  a_err_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_error_r && out_region_r == plmi_pkg::REGION_INSIDE))
    else $error("error flag on an inside result");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_pos_r == '0 && !out_sat_r))
    else $error("error result not zeroed");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_pos_r == {1'b1, {(PW-1){1'b0}}} || out_pos_r == {1'b0, {(PW-1){1'b1}}}))
    else $error("saturated result off the rail");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && pend_r) |-> chk_r <= last_n)
    else $error("scan checked past the last knot");

endmodule
`default_nettype wire

// File: sim/piecewise_linear_map_interpolator_tb.sv
`default_nettype none
module piecewise_linear_map_interpolator_tb;

  localparam int ITEM_GOAL     = 1425;
  localparam int REGIME_A_END  = 500;
  localparam int REGIME_B_END  = 1000;
  localparam int SETTLE_CYCLES = 400;
  localparam int DRAIN_CYCLES  = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int REPORT_MAX    = 10;

  localparam longint POS_MAX = (64'sd1 <<< (plmi_pkg::POS_W - 1)) - 1;
  localparam longint POS_MIN = -(64'sd1 <<< (plmi_pkg::POS_W - 1));
  localparam logic [63:0] QUOT_CAP = 64'd1 << plmi_pkg::TERM_EXP;

  typedef enum logic [1:0] {STEP_LOAD, STEP_QUERY, STEP_COUNT} step_kind_t;

  typedef struct packed {
    logic                        kind;
    logic [plmi_pkg::KIDX_W-1:0] knot_index;
    logic [plmi_pkg::POS_W-1:0]  old_knot;
    logic [plmi_pkg::POS_W-1:0]  new_knot;
    logic [plmi_pkg::POS_W-1:0]  query_position;
  } knot_item_t;

  typedef struct packed {
    logic [plmi_pkg::POS_W-1:0]    mapped_position;
    logic [plmi_pkg::REGION_W-1:0] region;
    logic                          error;
    logic                          saturated;
  } mapped_result_t;

  typedef struct {
    step_kind_t     step;
    logic [7:0]     idx;
    logic [31:0]    a;
    logic [31:0]    b;
    logic           typed;
    mapped_result_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  plmi_in_if  in_ch();
  plmi_out_if out_ch();
  plmi_cfg_if cfg_ch();

  piecewise_linear_map_interpolator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [plmi_pkg::POS_W-1:0] old_map [plmi_pkg::MAP_DEPTH];
  logic signed [plmi_pkg::POS_W-1:0] new_map [plmi_pkg::MAP_DEPTH];
  logic [plmi_pkg::KCNT_W-1:0]       knot_count_q;
  mapped_result_t                    pending_results[$];

  int src_idle_pct;
  int sink_idle_pct;
  int items_sent;
  int loads_sent;
  int queries_sent;
  int count_writes;
  int results_seen;
  int mismatches;
  int flagged;
  int region_tally[3];

  function automatic int active_knots();
    if (knot_count_q == 0) return 1;
    if (knot_count_q > plmi_pkg::MAP_DEPTH) return plmi_pkg::MAP_DEPTH;
    return int'(knot_count_q);
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic longint rand_signed(input int shift);
    return longint'($signed($urandom)) >>> shift;
  endfunction

  // trunc(a*b/c), magnitude capped before the final add
  function automatic longint scaled_quotient(input longint a, input longint b, input longint c);
    logic        neg;
    logic [63:0] ua, ub, uc, q;
    neg = 1'b0;
    if (a < 0) begin
      neg = ~neg;
      ua = 64'(-a);
    end else begin
      ua = 64'(a);
    end
    if (b < 0) begin
      neg = ~neg;
      ub = 64'(-b);
    end else begin
      ub = 64'(b);
    end
    if (c < 0) begin
      neg = ~neg;
      uc = 64'(-c);
    end else begin
      uc = 64'(c);
    end
    if (uc == 0) return 0;
    q = (ua * ub) / uc;
    if (q > QUOT_CAP) q = QUOT_CAP;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic mapped_result_t map_position(input logic signed [plmi_pkg::POS_W-1:0] q);
    mapped_result_t r;
    int     n, k, last;
    longint pos, total, old_len, new_len;
    n    = active_knots();
    pos  = longint'(q);
    last = -1;
    k    = 0;
    while (k < n && old_map[k] <= q) begin
      last = k;
      k++;
    end
    r.error     = 1'b0;
    r.saturated = 1'b0;
    if (last < 0 || last == n - 1) begin
      old_len  = longint'(old_map[n-1]) - longint'(old_map[0]);
      new_len  = longint'(new_map[n-1]) - longint'(new_map[0]);
      r.region = (last < 0) ? plmi_pkg::REGION_LEFT : plmi_pkg::REGION_RIGHT;
      if (old_len == 0) begin
        r.error = 1'b1;
        total   = 0;
      end else if (last < 0) begin
        total = longint'(new_map[0])
              - scaled_quotient(longint'(old_map[0]) - pos, new_len, old_len);
      end else begin
        total = longint'(new_map[n-1])
              + scaled_quotient(pos - longint'(old_map[n-1]), new_len, old_len);
      end
    end else begin
      r.region = plmi_pkg::REGION_INSIDE;
      total = longint'(new_map[last])
            + scaled_quotient(pos - longint'(old_map[last]),
                              longint'(new_map[last+1]) - longint'(new_map[last]),
                              longint'(old_map[last+1]) - longint'(old_map[last]));
    end
    if (total > POS_MAX || total < POS_MIN) r.saturated = 1'b1;
    total = clamp_pos(total);
    r.mapped_position = total[plmi_pkg::POS_W-1:0];
    return r;
  endfunction

  function automatic knot_item_t load_item(input logic [7:0] idx, input logic [31:0] o,
                                           input logic [31:0] w);
    knot_item_t it;
    it = '0;
    it.kind       = plmi_pkg::KIND_LOAD;
    it.knot_index = idx;
    it.old_knot   = o;
    it.new_knot   = w;
    return it;
  endfunction

  function automatic knot_item_t query_item(input logic [31:0] q);
    knot_item_t it;
    it = '0;
    it.kind           = plmi_pkg::KIND_QUERY;
    it.query_position = q;
    return it;
  endfunction

  function automatic mapped_result_t res(input logic [31:0] p, input logic [1:0] rg,
                                         input logic e, input logic s);
    return {p, rg, e, s};
  endfunction

  function automatic plan_row_t row_load(input logic [7:0] idx, input logic [31:0] o,
                                         input logic [31:0] w);
    plan_row_t r;
    r.step = STEP_LOAD; r.idx = idx; r.a = o; r.b = w; r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t row_query(input logic [31:0] q, input logic typed,
                                          input mapped_result_t want);
    plan_row_t r;
    r.step = STEP_QUERY; r.idx = '0; r.a = q; r.b = '0; r.typed = typed; r.want = want;
    return r;
  endfunction

  function automatic plan_row_t row_count(input logic [8:0] v);
    plan_row_t r;
    r.step = STEP_COUNT; r.idx = '0; r.a = 32'(v); r.b = '0; r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input knot_item_t it, input logic typed, input mapped_result_t want);
    mapped_result_t exp_res;
    if (items_sent < REGIME_A_END) begin
      src_idle_pct  = 30;
      sink_idle_pct = 81;
    end else if (items_sent < REGIME_B_END) begin
      src_idle_pct  = 81;
      sink_idle_pct = 30;
    end else begin
      src_idle_pct  = 0;
      sink_idle_pct = 0;
    end
    while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    in_ch.kind           = it.kind;
    in_ch.knot_index     = it.knot_index;
    in_ch.old_knot       = it.old_knot;
    in_ch.new_knot       = it.new_knot;
    in_ch.query_position = it.query_position;
    in_ch.valid          = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (it.kind == plmi_pkg::KIND_LOAD) begin
      old_map[it.knot_index] = it.old_knot;
      new_map[it.knot_index] = it.new_knot;
      loads_sent++;
    end else begin
      exp_res = typed ? want : map_position(it.query_position);
      pending_results.push_back(exp_res);
      queries_sent++;
      if (exp_res.region <= plmi_pkg::REGION_RIGHT) region_tally[exp_res.region]++;
      if (exp_res.error) flagged++;
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // only while the block is idle
  task automatic write_knot_count(input logic [plmi_pkg::KCNT_W-1:0] value);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    knot_count_q = value;
    count_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic run_map_phase(input int phase);
    int         pick, style, n, k, nq;
    longint     o, w;
    logic [8:0] cnt;
    pick = $urandom_range(99);
    if (phase == 0) cnt = 9'd256;
    else if (phase == 1) cnt = 9'd511;
    else if (pick < 2) cnt = 9'($urandom_range(257, 511));
    else if (pick < 4) cnt = 9'd256;
    else if (pick < 12) cnt = 9'($urandom_range(0, 1));
    else if (pick < 60) cnt = 9'($urandom_range(2, 6));
    else cnt = 9'($urandom_range(7, 40));
    write_knot_count(cnt);
    n = active_knots();
    // 0..6 sorted, 7 sorted with repeated knots, 8..9 raw
    style = $urandom_range(9);
    o = rand_signed($urandom_range(0, 31));
    w = rand_signed($urandom_range(0, 31));
    if (phase != 1) begin
      for (k = 0; k < n; k++) begin
        if (style >= 8) begin
          o = rand_signed(0);
          w = rand_signed(0);
        end
        send_item(load_item(8'(k), o[31:0], w[31:0]), 1'b0, '0);
        if (style == 7 && $urandom_range(2) == 0) o = o;
        else o = clamp_pos(o + longint'($urandom_range(1, 1 << $urandom_range(0, 26))));
        w = clamp_pos(w + rand_signed($urandom_range(3, 31)));
      end
    end
    nq = $urandom_range(8, 30);
    repeat (nq) begin
      pick = $urandom_range(99);
      k    = $urandom_range(0, n - 1);
      if (pick < 8) begin
        send_item(load_item(8'($urandom_range(0, 255)), $urandom, $urandom), 1'b0, '0);
      end else if (pick < 28) begin
        send_item(query_item(old_map[k]), 1'b0, '0);
      end else if (pick < 40) begin
        send_item(query_item($urandom), 1'b0, '0);
      end else begin
        o = clamp_pos(longint'(old_map[k]) + rand_signed($urandom_range(4, 31)));
        send_item(query_item(o[31:0]), 1'b0, '0);
      end
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    mapped_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.mapped_position, out_ch.region, out_ch.error, out_ch.saturated};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch %0d at %0t: unexpected result pos=%h reg=%0d err=%b sat=%b",
                   mismatches, $time, got.mapped_position, got.region, got.error,
                   got.saturated);
      end else begin
        want = pending_results.pop_front();
        if (got.mapped_position !== want.mapped_position || got.region !== want.region ||
            got.error !== want.error || got.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch %0d at %0t: exp pos=%h reg=%0d err=%b sat=%b, got pos=%h %s",
                     mismatches, $time, want.mapped_position, want.region, want.error,
                     want.saturated, got.mapped_position,
                     $sformatf("reg=%0d err=%b sat=%b", got.region, got.error,
                               got.saturated));
        end
      end
    end
  end

  initial begin
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    plan_row_t plan[$];
    int        phase;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.kind           = plmi_pkg::KIND_LOAD;
    in_ch.knot_index     = '0;
    in_ch.old_knot       = '0;
    in_ch.new_knot       = '0;
    in_ch.query_position = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    src_idle_pct         = 30;
    sink_idle_pct        = 81;
    knot_count_q         = plmi_pkg::KCNT_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // two knots at reset count: (0,0) and (1.0,2.0)
    plan.push_back(row_load(8'd0, 32'h0000_0000, 32'h0000_0000));
    plan.push_back(row_load(8'd1, 32'h0001_0000, 32'h0002_0000));
    plan.push_back(row_query(32'h0000_8000, 1'b1,
                             res(32'h0001_0000, plmi_pkg::REGION_INSIDE, 1'b0, 1'b0)));
    plan.push_back(row_query(32'h0001_0000, 1'b1,
                             res(32'h0002_0000, plmi_pkg::REGION_RIGHT, 1'b0, 1'b0)));
    plan.push_back(row_query(32'hFFFF_0000, 1'b1,
                             res(32'hFFFE_0000, plmi_pkg::REGION_LEFT, 1'b0, 1'b0)));
    plan.push_back(row_query(32'h7FFF_FFFF, 1'b1,
                             res(32'h7FFF_FFFF, plmi_pkg::REGION_RIGHT, 1'b0, 1'b1)));
    plan.push_back(row_query(32'h8000_0000, 1'b1,
                             res(32'h8000_0000, plmi_pkg::REGION_LEFT, 1'b0, 1'b1)));
    // tiny old length, quotient clipped
    plan.push_back(row_load(8'd1, 32'h0000_0001, 32'h7FFF_FFFF));
    plan.push_back(row_query(32'h7FFF_FFFF, 1'b1,
                             res(32'h7FFF_FFFF, plmi_pkg::REGION_RIGHT, 1'b0, 1'b1)));
    // zero old length
    plan.push_back(row_load(8'd1, 32'h0000_0000, 32'h0001_0000));
    plan.push_back(row_query(32'h0000_0005, 1'b1,
                             res(32'h0, plmi_pkg::REGION_RIGHT, 1'b1, 1'b0)));
    plan.push_back(row_query(32'hFFFF_FFFB, 1'b1,
                             res(32'h0, plmi_pkg::REGION_LEFT, 1'b1, 1'b0)));
    // count 0 acts as a single knot
    plan.push_back(row_count(9'd0));
    plan.push_back(row_query(32'h0000_0000, 1'b1,
                             res(32'h0, plmi_pkg::REGION_RIGHT, 1'b1, 1'b0)));
    plan.push_back(row_query(32'h8000_0000, 1'b1,
                             res(32'h0, plmi_pkg::REGION_LEFT, 1'b1, 1'b0)));
    plan.push_back(row_count(9'd1));
    plan.push_back(row_query(32'h7FFF_FFFF, 1'b1,
                             res(32'h0, plmi_pkg::REGION_RIGHT, 1'b1, 1'b0)));
    // unsorted map, negative overall old length
    plan.push_back(row_load(8'd255, 32'h8000_0000, 32'h7FFF_FFFF));
    plan.push_back(row_load(8'd0, 32'h0002_0000, 32'h8000_0000));
    plan.push_back(row_load(8'd1, 32'h0003_0000, 32'h7FFF_FFFF));
    plan.push_back(row_load(8'd2, 32'h0001_0000, 32'h0000_0000));
    plan.push_back(row_count(9'd3));
    plan.push_back(row_query(32'h0002_8000, 1'b0, '0));
    plan.push_back(row_query(32'h0004_0000, 1'b0, '0));
    plan.push_back(row_query(32'h0001_8000, 1'b0, '0));

    foreach (plan[i]) begin
      case (plan[i].step)
        STEP_COUNT: write_knot_count(plan[i].a[plmi_pkg::KCNT_W-1:0]);
        STEP_LOAD:  send_item(load_item(plan[i].idx, plan[i].a, plan[i].b), 1'b0, '0);
        default:    send_item(query_item(plan[i].a), plan[i].typed, plan[i].want);
      endcase
    end

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      run_map_phase(phase);
      phase++;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d knot loads, %0d queries (left %0d, inside %0d, right %0d), %0d %s",
             loads_sent, queries_sent, region_tally[0], region_tally[1], region_tally[2],
             flagged, "with zero old length");
    $display("%0d knot count writes over %0d map phases, %0d results checked, %0d mismatches",
             count_writes, phase, results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/plmi_pkg.sv
rtl/plmi_if.sv
rtl/plmi_knot_mem.sv
rtl/plmi_div.sv
rtl/piecewise_linear_map_interpolator.sv
sim/piecewise_linear_map_interpolator_tb.sv
